FILE: hw/rtl/rgb_to_ycbcr_chroma_subsampler_top_assert.svh
// assertion macros for the rgb to ycbcr chroma subsampler
`ifndef RGB_TO_YCBCR_CHROMA_SUBSAMPLER_TOP_ASSERT_SVH
`define RGB_TO_YCBCR_CHROMA_SUBSAMPLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every rising clock edge outside reset
`define RYC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every rising clock edge, reset included
`define RYC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RYC_ASSERT(lbl, clk, rst, prop, msg)
`define RYC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/ryc_pkg.sv
// shared constants and helpers for the rgb to ycbcr chroma subsampler
`default_nettype none

package ryc_pkg;

  // field widths
  localparam int PIX_W    = 24;
  localparam int NPIX     = 4;
  localparam int LUMA_W   = 8;
  localparam int CHROMA_W = 9;
  localparam int MODE_W   = 2;

  // subsample mode codes
  localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

  // bt.601 luma coefficients, 8 fractional bits
  localparam logic [15:0] Y_R   = 16'd77;
  localparam logic [15:0] Y_G   = 16'd150;
  localparam logic [15:0] Y_B   = 16'd29;
  localparam logic [15:0] Y_RND = 16'd128;

  // bt.601 chroma coefficients, 8 fractional bits
  localparam logic signed [17:0] CB_R  = -18'sd43;
  localparam logic signed [17:0] CB_G  = -18'sd85;
  localparam logic signed [17:0] CB_B  = 18'sd128;
  localparam logic signed [17:0] CR_R  = 18'sd128;
  localparam logic signed [17:0] CR_G  = -18'sd107;
  localparam logic signed [17:0] CR_B  = -18'sd21;
  localparam logic signed [17:0] C_RND = 18'sd128;

  // reciprocal of three, 11 fractional bits, exact for values below 2048
  localparam logic [9:0] RECIP3 = 10'd683;

  // pixels covered by each mode; the spare code acts as 4:2:0
  function automatic logic [NPIX-1:0] used_mask(input logic [MODE_W-1:0] mode);
    logic [NPIX-1:0] m;
    unique case (mode)
      MODE_444: m = 4'b0001;
      MODE_422: m = 4'b0011;
      default:  m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_group_if.sv
// input channel: one group of up to four rgb888 pixels with its valid mask
`default_nettype none

interface rgb_group_if;
  logic                        valid;
  logic                        ready;
  logic [ryc_pkg::PIX_W-1:0]   pixel_top_left;
  logic [ryc_pkg::PIX_W-1:0]   pixel_top_right;
  logic [ryc_pkg::PIX_W-1:0]   pixel_bottom_left;
  logic [ryc_pkg::PIX_W-1:0]   pixel_bottom_right;
  logic [ryc_pkg::NPIX-1:0]    pixel_valid;

  modport source (
    output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, pixel_valid,
    input  ready
  );
  modport sink (
    input  valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, pixel_valid,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/ycc_result_if.sv
// output channel: four luma samples and one averaged chroma pair
`default_nettype none

interface ycc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma_top_left;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma_top_right;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma_bottom_left;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma_bottom_right;
  logic signed [ryc_pkg::CHROMA_W-1:0] chroma_blue;
  logic signed [ryc_pkg::CHROMA_W-1:0] chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/rgb_to_ycbcr_chroma_subsampler_top.sv
// top level: pipelined bt.601 rgb to ycbcr converter with chroma averaging
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    four rgb888 pixels, 4-bit pixel mask
// out_ch    out  valid/ready    four 8-bit lumas, 9-bit cb and cr
// cfg       in   cfg_we         2-bit subsample mode, no read-back
//
// one item per cycle unless out_ch stalls; out_ch.valid is ov, fed through v1 to v4
// stages: input reg, per-pixel convert, chroma sum, rounding, divide/output reg
// each stage loads when it is empty or the stage after it moves on
// a stalled output holds its item; earlier stages keep filling until full
// rst is synchronous and clears the stage valids; mode resets to 4:2:0
`default_nettype none

`include "rgb_to_ycbcr_chroma_subsampler_top_assert.svh"

module rgb_to_ycbcr_chroma_subsampler_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  rgb_group_if.sink                       in_ch,
  ycc_result_if.source                    out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [ryc_pkg::MODE_W-1:0] cfg_wdata
);

  localparam int N = ryc_pkg::NPIX;

  // configuration register
  logic [ryc_pkg::MODE_W-1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ryc_pkg::MODE_420;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // stage valids and load enables
  logic v1, v2, v3, v4, ov;
  logic en1, en2, en3, en4, en5;

  assign en5 = !ov || out_ch.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1) v1 <= in_ch.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) ov <= v4;
    end
  end

  // stage 1: capture pixels and mask out pixels the mode does not cover
  logic [ryc_pkg::PIX_W-1:0] px1 [N];
  logic [N-1:0]              mask1;

  always_ff @(posedge clk) begin
    if (en1) begin
      px1[0] <= in_ch.pixel_top_left;
      px1[1] <= in_ch.pixel_top_right;
      px1[2] <= in_ch.pixel_bottom_left;
      px1[3] <= in_ch.pixel_bottom_right;
      mask1  <= in_ch.pixel_valid & ryc_pkg::used_mask(mode);
    end
  end

  // stage 2: per-pixel luma and chroma
  logic [15:0]                         ysum  [N];
  logic signed [17:0]                  cbv   [N];
  logic signed [17:0]                  crv   [N];
  logic signed [ryc_pkg::LUMA_W-1:0]   luma_c[N];
  logic signed [ryc_pkg::LUMA_W-1:0]   luma2 [N];
  logic signed [ryc_pkg::CHROMA_W-1:0] cb2   [N];
  logic signed [ryc_pkg::CHROMA_W-1:0] cr2   [N];
  logic [N-1:0]                        mask2;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      ysum[k] = {8'b0, px1[k][23:16]} * ryc_pkg::Y_R
              + {8'b0, px1[k][15:8]}  * ryc_pkg::Y_G
              + {8'b0, px1[k][7:0]}   * ryc_pkg::Y_B
              + ryc_pkg::Y_RND;
      cbv[k] = $signed({10'b0, px1[k][23:16]}) * ryc_pkg::CB_R
             + $signed({10'b0, px1[k][15:8]})  * ryc_pkg::CB_G
             + $signed({10'b0, px1[k][7:0]})   * ryc_pkg::CB_B
             + ryc_pkg::C_RND;
      crv[k] = $signed({10'b0, px1[k][23:16]}) * ryc_pkg::CR_R
             + $signed({10'b0, px1[k][15:8]})  * ryc_pkg::CR_G
             + $signed({10'b0, px1[k][7:0]})   * ryc_pkg::CR_B
             + ryc_pkg::C_RND;
      // minus 128 on the high byte is a flip of its top bit
      luma_c[k] = mask1[k] ? $signed({~ysum[k][15], ysum[k][14:8]})
                           : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < N; k++) begin
        luma2[k] <= luma_c[k];
        // floor divide by 256
        cb2[k]   <= cbv[k][16:8];
        cr2[k]   <= crv[k][16:8];
      end
      mask2 <= mask1;
    end
  end

  // stage 3: chroma sums and pixel count
  logic signed [10:0]                  cb_acc, cr_acc;
  logic signed [10:0]                  cb3, cr3;
  logic [2:0]                          cnt3;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma3 [N];

  always_comb begin
    cb_acc = '0;
    cr_acc = '0;
    for (int k = 0; k < N; k++) begin
      if (mask2[k]) begin
        cb_acc = cb_acc + 11'(cb2[k]);
        cr_acc = cr_acc + 11'(cr2[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cb3   <= cb_acc;
      cr3   <= cr_acc;
      cnt3  <= 3'($countones(mask2));
      luma3 <= luma2;
    end
  end

  // stage 4: magnitude plus half the count, sign kept aside
  logic [9:0]                          cb_abs, cr_abs;
  logic [9:0]                          cb_mag4, cr_mag4;
  logic                                cb_neg4, cr_neg4;
  logic [2:0]                          cnt4;
  logic signed [ryc_pkg::LUMA_W-1:0]   luma4 [N];

  always_comb begin
    cb_abs = cb3[10] ? 10'(-cb3) : cb3[9:0];
    cr_abs = cr3[10] ? 10'(-cr3) : cr3[9:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      cb_mag4 <= (cnt3 == 3'd0) ? '0 : cb_abs + {8'b0, cnt3[2:1]};
      cr_mag4 <= (cnt3 == 3'd0) ? '0 : cr_abs + {8'b0, cnt3[2:1]};
      cb_neg4 <= cb3[10];
      cr_neg4 <= cr3[10];
      cnt4    <= cnt3;
      luma4   <= luma3;
    end
  end

  // stage 5: divide by the count (one to four) and restore the sign
  logic [19:0]                         cb_m3, cr_m3;
  logic [8:0]                          cb_q, cr_q;
  logic signed [ryc_pkg::CHROMA_W-1:0] cb_res, cr_res;

  assign cb_m3 = cb_mag4 * ryc_pkg::RECIP3;
  assign cr_m3 = cr_mag4 * ryc_pkg::RECIP3;

  always_comb begin
    case (cnt4)
      3'd1:    begin cb_q = cb_mag4[8:0];         cr_q = cr_mag4[8:0];         end
      3'd2:    begin cb_q = {1'b0, cb_mag4[9:2]} + 9'(cb_mag4[1]);
                     cr_q = {1'b0, cr_mag4[9:2]} + 9'(cr_mag4[1]);             end
      3'd3:    begin cb_q = cb_m3[19:11];         cr_q = cr_m3[19:11];         end
      3'd4:    begin cb_q = {2'b0, cb_mag4[9:3]} + 9'(cb_mag4[2]);
                     cr_q = {2'b0, cr_mag4[9:3]} + 9'(cr_mag4[2]);             end
      default: begin cb_q = '0;                   cr_q = '0;                   end
    endcase
  end

  // halving as mag>>1, quartering as mag>>2
  logic [8:0] cb_qq, cr_qq;
  always_comb begin
    cb_qq = cb_q;
    cr_qq = cr_q;
    if (cnt4 == 3'd2) begin
      cb_qq = cb_mag4[9:1];
      cr_qq = cr_mag4[9:1];
    end else if (cnt4 == 3'd4) begin
      cb_qq = {1'b0, cb_mag4[9:2]};
      cr_qq = {1'b0, cr_mag4[9:2]};
    end
    cb_res = cb_neg4 ? $signed(9'(-cb_qq)) : $signed(cb_qq);
    cr_res = cr_neg4 ? $signed(9'(-cr_qq)) : $signed(cr_qq);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_ch.luma_top_left     <= luma4[0];
      out_ch.luma_top_right    <= luma4[1];
      out_ch.luma_bottom_left  <= luma4[2];
      out_ch.luma_bottom_right <= luma4[3];
      out_ch.chroma_blue       <= cb_res;
      out_ch.chroma_red        <= cr_res;
    end
  end

  assign out_ch.valid = ov;

  // checks
  `RYC_ASSERT(a_cnt_matches_mask, clk, rst,
    (v2 && en3) |=> (cnt3 == 3'($countones($past(mask2)))), "pixel count lost its mask")
  `RYC_ASSERT(a_stall_holds_stage4, clk, rst,
    (v4 && !en4) |=> (v4 && $stable(cb_mag4) && $stable(cnt4)), "stalled item left stage 4")
  `RYC_ASSERT(a_empty_group_zero, clk, rst,
    (v4 && cnt4 == 3'd0) |-> (cb_mag4 == 10'd0 && cr_mag4 == 10'd0), "chroma without pixels")
  `RYC_ASSERT(a_chroma_range, clk, rst,
    ov |-> (out_ch.chroma_blue >= -9'sd127 && out_ch.chroma_red >= -9'sd127),
    "chroma average out of range")

endmodule

`default_nettype wire

FILE: tb/rgb_to_ycbcr_chroma_subsampler_top_test.sv
// testbench for the rgb to ycbcr chroma subsampler: directed, random and back-pressure runs
`timescale 1ns / 100ps
`default_nettype none

module rgb_to_ycbcr_chroma_subsampler_top_test;

  // field widths taken from the package
  localparam int PIX_W    = ryc_pkg::PIX_W;
  localparam int NPIX     = ryc_pkg::NPIX;
  localparam int LUMA_W   = ryc_pkg::LUMA_W;
  localparam int CHROMA_W = ryc_pkg::CHROMA_W;
  localparam int MODE_W   = ryc_pkg::MODE_W;

  // spare mode code, expected to act as 4:2:0
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 40;
  localparam int TIMEOUT_NS   = 400000;

  // one group of pixels as offered on the input channel, index 0 is top left
  typedef struct packed {
    logic [NPIX-1:0][PIX_W-1:0] pixels;
    logic [NPIX-1:0]            mask;
  } rgb_group_t;

  // one converted group as seen on the output channel
  typedef struct packed {
    logic [NPIX-1:0][LUMA_W-1:0] luma;
    logic [CHROMA_W-1:0]         cb;
    logic [CHROMA_W-1:0]         cr;
  } ycc_group_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  rgb_group_if  in_ch ();
  ycc_result_if out_ch ();

  rgb_to_ycbcr_chroma_subsampler_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ycc_group_t  ycc_expected_q[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  logic [MODE_W-1:0] active_mode;

  // bt.601 conversion of one group under the given mode
  function automatic ycc_group_t convert_group(input rgb_group_t grp,
                                               input logic [MODE_W-1:0] mode);
    logic [NPIX-1:0] covered;
    logic [NPIX-1:0] live;
    int red, green, blue;
    int cb_acc, cr_acc, n, mag, q;
    ycc_group_t res;
    case (mode)
      ryc_pkg::MODE_444: covered = 4'b0001;
      ryc_pkg::MODE_422: covered = 4'b0011;
      default:           covered = 4'b1111;
    endcase
    live   = grp.mask & covered;
    res    = '0;
    cb_acc = 0;
    cr_acc = 0;
    n      = 0;
    for (int k = 0; k < NPIX; k++) begin
      if (live[k]) begin
        red   = int'(grp.pixels[k][23:16]);
        green = int'(grp.pixels[k][15:8]);
        blue  = int'(grp.pixels[k][7:0]);
        res.luma[k] = LUMA_W'(((77 * red + 150 * green + 29 * blue + 128) >>> 8) - 128);
        // per-pixel chroma rounds toward minus infinity
        cb_acc += (-43 * red - 85 * green + 128 * blue + 128) >>> 8;
        cr_acc += (128 * red - 107 * green - 21 * blue + 128) >>> 8;
        n++;
      end
    end
    // average with ties going away from zero
    if (n > 0) begin
      mag = (cb_acc < 0) ? -cb_acc : cb_acc;
      q   = (mag + n / 2) / n;
      res.cb = CHROMA_W'((cb_acc < 0) ? -q : q);
      mag = (cr_acc < 0) ? -cr_acc : cr_acc;
      q   = (mag + n / 2) / n;
      res.cr = CHROMA_W'((cr_acc < 0) ? -q : q);
    end
    return res;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (got != want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // predict on each accepted input item, check each accepted result item
  always @(posedge clk) begin
    rgb_group_t grp;
    ycc_group_t got, want;
    if (rst) begin
      active_mode = ryc_pkg::MODE_420;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        grp.pixels[0] = in_ch.pixel_top_left;
        grp.pixels[1] = in_ch.pixel_top_right;
        grp.pixels[2] = in_ch.pixel_bottom_left;
        grp.pixels[3] = in_ch.pixel_bottom_right;
        grp.mask      = in_ch.pixel_valid;
        ycc_expected_q.push_back(convert_group(grp, active_mode));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.luma[0] = out_ch.luma_top_left;
        got.luma[1] = out_ch.luma_top_right;
        got.luma[2] = out_ch.luma_bottom_left;
        got.luma[3] = out_ch.luma_bottom_right;
        got.cb      = out_ch.chroma_blue;
        got.cr      = out_ch.chroma_red;
        if (ycc_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none expected, expected none actual cb %0d cr %0d",
                     $time, $signed(got.cb), $signed(got.cr));
        end else begin
          want = ycc_expected_q.pop_front();
          check_field("luma_top_left", int'($signed(want.luma[0])),
                      int'($signed(got.luma[0])));
          check_field("luma_top_right", int'($signed(want.luma[1])),
                      int'($signed(got.luma[1])));
          check_field("luma_bottom_left", int'($signed(want.luma[2])),
                      int'($signed(got.luma[2])));
          check_field("luma_bottom_right", int'($signed(want.luma[3])),
                      int'($signed(got.luma[3])));
          check_field("chroma_blue", int'($signed(want.cb)), int'($signed(got.cb)));
          check_field("chroma_red", int'($signed(want.cr)), int'($signed(got.cr)));
        end
      end
      if (cfg_we)
        active_mode = cfg_wdata;
    end
  end

  // offer one item, return at the falling edge after it is taken
  task automatic send_group(input rgb_group_t grp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid              = 1'b1;
    in_ch.pixel_top_left     = grp.pixels[0];
    in_ch.pixel_top_right    = grp.pixels[1];
    in_ch.pixel_bottom_left  = grp.pixels[2];
    in_ch.pixel_bottom_right = grp.pixels[3];
    in_ch.pixel_valid        = grp.mask;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (ycc_expected_q.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  // mode change only with the pipeline empty
  task automatic set_subsample_mode(input logic [MODE_W-1:0] mode);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic rgb_group_t make_group(input logic [23:0] tl, input logic [23:0] tr,
                                            input logic [23:0] bl, input logic [23:0] br,
                                            input logic [NPIX-1:0] mask);
    rgb_group_t grp;
    grp.pixels[0] = tl;
    grp.pixels[1] = tr;
    grp.pixels[2] = bl;
    grp.pixels[3] = br;
    grp.mask      = mask;
    return grp;
  endfunction

  // channels lean toward the extremes now and then
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    px = PIX_W'($urandom_range(24'hFFFFFF));
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(7))
        0: px[c*8 +: 8] = 8'h00;
        1: px[c*8 +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return px;
  endfunction

  function automatic rgb_group_t random_group();
    logic [NPIX-1:0] mask;
    mask = ($urandom_range(99) < 55) ? 4'hF : 4'($urandom_range(15));
    return make_group(random_pixel(), random_pixel(), random_pixel(), random_pixel(), mask);
  endfunction

  // extremes of the pixel values, masks and every mode
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset mode is 4:2:0
    send_group(make_group(24'h000000, 24'h000000, 24'h000000, 24'h000000, 4'hF));
    send_group(make_group(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF));
    send_group(make_group(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 4'hF));
    send_group(make_group(24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000, 4'hF));
    send_group(make_group(24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 4'hF));
    // no pixel inside the image
    send_group(make_group(24'hFF00FF, 24'h00FFFF, 24'h123456, 24'hABCDEF, 4'h0));
    // three valid pixels divide by three
    send_group(make_group(24'h0000FF, 24'h000000, 24'h0000FE, 24'hFFFFFF, 4'b0111));
    send_group(make_group(24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F, 4'b1000));
    // tie in the average: one pixel at zero chroma, one just off
    send_group(make_group(24'h000000, 24'h000002, 24'h000000, 24'h000000, 4'b0011));
    send_group(make_group(24'h000000, 24'h020000, 24'h000000, 24'h000000, 4'b0011));
    send_group(make_group(24'h000000, 24'h000200, 24'h000000, 24'h000000, 4'b0011));
    // 4:4:4 ignores the other mask bits
    set_subsample_mode(ryc_pkg::MODE_444);
    send_group(make_group(24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF));
    send_group(make_group(24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'h00FF00, 4'b1110));
    send_group(make_group(24'hFF0000, 24'h000000, 24'h000000, 24'h000000, 4'b0001));
    // 4:2:2 covers the top pair only
    set_subsample_mode(ryc_pkg::MODE_422);
    send_group(make_group(24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 4'b0011));
    send_group(make_group(24'hFF0000, 24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 4'b1100));
    send_group(make_group(24'hFF0000, 24'h00FF00, 24'hFFFFFF, 24'hFFFFFF, 4'b1110));
    // spare code acts as 4:2:0
    set_subsample_mode(MODE_SPARE);
    send_group(make_group(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 4'hF));
    send_group(make_group(24'hFFFFFF, 24'h000000, 24'hFFFF00, 24'h0000FF, 4'b0101));
    send_group(make_group(24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 4'b1000));
  endtask

  // random items under one mode and one idling profile
  task automatic test_random_phase(input logic [MODE_W-1:0] mode, input int count,
                                   input int idle_pct, input int stall_pct);
    set_subsample_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_group(random_group());
  endtask

  // long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    set_subsample_mode(ryc_pkg::MODE_420);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (40) send_group(random_group());
  endtask

  // stimulus sequence
  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_wdata                = ryc_pkg::MODE_420;
    in_ch.valid              = 1'b0;
    in_ch.pixel_top_left     = '0;
    in_ch.pixel_top_right    = '0;
    in_ch.pixel_bottom_left  = '0;
    in_ch.pixel_bottom_right = '0;
    in_ch.pixel_valid        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(ryc_pkg::MODE_444, 215,  0,  0);
    test_random_phase(ryc_pkg::MODE_422, 215,  0,  0);
    test_random_phase(ryc_pkg::MODE_420, 215, 57,  0);
    test_random_phase(MODE_SPARE,        215, 57,  0);
    test_random_phase(ryc_pkg::MODE_444, 215,  0, 57);
    test_random_phase(ryc_pkg::MODE_422, 215,  0, 57);
    test_random_phase(ryc_pkg::MODE_420, 215, 22, 22);
    test_random_phase(MODE_SPARE,        215, 22, 22);
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
